FILE: rtl/tms_pkg.sv
// Shared constants and codes for the Turing machine stepper.
package tms_pkg;

  // Default sizes of the machine.
  localparam int unsigned TapeDepthDefault  = 1024;
  localparam int unsigned MaxRulesDefault   = 64;
  localparam int unsigned StateBitsDefault  = 4;
  localparam int unsigned SymbolBitsDefault = 4;

  // Fixed field widths.
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;

  // Request function codes.
  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD_RULE = 2'd0,
    FUNC_LOAD_CELL = 2'd1,
    FUNC_RESTART   = 2'd2,
    FUNC_STEP      = 2'd3
  } func_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_NO_MATCH = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_ACK      = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_STATE = 2'd0,
    CFG_START_HEAD  = 2'd1,
    CFG_RULE_COUNT  = 2'd2
  } cfg_idx_e;

endpackage

FILE: rtl/tms_tape.sv
// Tape memory with a one-cell-per-cycle clearing pass after reset.
module tms_tape #(
  parameter int unsigned TAPE_DEPTH  = tms_pkg::TapeDepthDefault,
  parameter int unsigned SYMBOL_BITS = tms_pkg::SymbolBitsDefault,
  localparam int unsigned AddrW      = $clog2(TAPE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic                   wr_en_i,
  input  logic [AddrW-1:0]       addr_i,
  input  logic [SYMBOL_BITS-1:0] wdata_i,
  output logic [SYMBOL_BITS-1:0] rdata_o,
  output logic                   busy_o
);
  import tms_pkg::*;

  logic [SYMBOL_BITS-1:0] mem [TAPE_DEPTH];
  logic [SYMBOL_BITS-1:0] rdata_q;
  logic                   clr_busy_q, clr_busy_d;
  logic [AddrW-1:0]       clr_addr_q, clr_addr_d;

  // Clearing sweep walks every cell once after reset.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(TAPE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Single write port shared by the sweep and the user, registered read.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

FILE: rtl/turing_machine_stepper_unit.sv
// Top level of the single-tape Turing machine stepper.
// Each request loads a rule, loads a tape cell, restarts the machine or runs one
// step, and gives exactly one result. Loads and restarts are acknowledged at
// once. A step reads the tape cell under the head first, then reads the rule
// table memory one entry per cycle and compares it against the state and symbol
// until the first match, comparing at most min(rule_count, MAX_RULES) entries.
// The block works on one request at a time. A result sits in an output register,
// and a new request is taken only when that register is free or being emptied.
// After reset the tape is cleared to blank one cell per cycle, and no request is
// taken meanwhile; configuration writes are always taken. Searching a rule entry
// that was never loaded gives undefined results.
module turing_machine_stepper_unit #(
  parameter int unsigned TAPE_DEPTH  = tms_pkg::TapeDepthDefault,
  parameter int unsigned MAX_RULES   = tms_pkg::MaxRulesDefault,
  parameter int unsigned STATE_BITS  = tms_pkg::StateBitsDefault,
  parameter int unsigned SYMBOL_BITS = tms_pkg::SymbolBitsDefault,
  localparam int unsigned HeadW      = $clog2(TAPE_DEPTH),
  localparam int unsigned RuleIdxW   = $clog2(MAX_RULES),
  localparam int unsigned CountW     = $clog2(MAX_RULES + 1),
  localparam int unsigned CfgDataW01 = (STATE_BITS > HeadW) ? STATE_BITS : HeadW,
  localparam int unsigned CfgDataW   = (CfgDataW01 > CountW) ? CfgDataW01 : CountW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tms_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0]          cfg_data_i,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tms_pkg::FuncW-1:0]    func_i,
  input  logic [RuleIdxW-1:0]          rule_index_i,
  input  logic [STATE_BITS-1:0]        rule_from_state_i,
  input  logic [SYMBOL_BITS-1:0]       rule_read_symbol_i,
  input  logic [STATE_BITS-1:0]        rule_next_state_i,
  input  logic [SYMBOL_BITS-1:0]       rule_write_symbol_i,
  input  logic                         rule_go_right_i,
  input  logic [HeadW-1:0]             cell_address_i,
  input  logic [SYMBOL_BITS-1:0]       cell_symbol_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tms_pkg::StatusW-1:0]  status_o,
  output logic [STATE_BITS-1:0]        current_state_o,
  output logic [HeadW-1:0]             head_cell_o,
  output logic [SYMBOL_BITS-1:0]       symbol_seen_o,
  output logic [SYMBOL_BITS-1:0]       symbol_put_o,
  output logic                         went_right_o
);
  import tms_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  typedef struct packed {
    logic [STATE_BITS-1:0]  from_state;
    logic [SYMBOL_BITS-1:0] read_symbol;
    logic [STATE_BITS-1:0]  next_state;
    logic [SYMBOL_BITS-1:0] write_symbol;
    logic                   go_right;
  } rule_t;

  state_e                 state_q, state_d;
  logic [RuleIdxW-1:0]    idx_q, idx_d;
  logic [STATE_BITS-1:0]  machine_q, machine_d;
  logic [HeadW-1:0]       head_q, head_d;
  logic [STATE_BITS-1:0]  start_state_q;
  logic [HeadW-1:0]       start_head_q;
  logic [CountW-1:0]      rule_count_q;

  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [STATE_BITS-1:0]  out_state_q, out_state_d;
  logic [HeadW-1:0]       out_head_q, out_head_d;
  logic [SYMBOL_BITS-1:0] out_seen_q, out_seen_d;
  logic [SYMBOL_BITS-1:0] out_put_q, out_put_d;
  logic                   out_right_q, out_right_d;

  rule_t                  rule_mem [MAX_RULES];
  rule_t                  rule_rd_q;
  rule_t                  rule_wr;
  logic                   rule_rd_en, rule_wr_en;
  logic [RuleIdxW-1:0]    rule_rd_addr;

  logic                   tape_rd_en, tape_wr_en, tape_busy;
  logic [HeadW-1:0]       tape_addr;
  logic [SYMBOL_BITS-1:0] tape_wdata, tape_rdata;

  logic                   out_free, accept;
  logic [CountW-1:0]      limit;
  logic                   last, match;
  logic [HeadW-1:0]       start_head_sat;

  // Handshake and scan bookkeeping.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && !tape_busy && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign limit = (rule_count_q < CountW'(MAX_RULES)) ? rule_count_q : CountW'(MAX_RULES);
  assign last  = (CountW'(idx_q) + CountW'(1)) == limit;
  assign match = (rule_rd_q.from_state == machine_q) && (rule_rd_q.read_symbol == tape_rdata);

  assign start_head_sat = ({1'b0, start_head_q} < (HeadW + 1)'(TAPE_DEPTH)) ?
                          start_head_q : HeadW'(TAPE_DEPTH - 1);

  assign rule_wr.from_state   = rule_from_state_i;
  assign rule_wr.read_symbol  = rule_read_symbol_i;
  assign rule_wr.next_state   = rule_next_state_i;
  assign rule_wr.write_symbol = rule_write_symbol_i;
  assign rule_wr.go_right     = rule_go_right_i;

  // Sequencer: request decode, tape read, then one rule compare per cycle.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    machine_d    = machine_q;
    head_d       = head_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_state_d  = out_state_q;
    out_head_d   = out_head_q;
    out_seen_d   = out_seen_q;
    out_put_d    = out_put_q;
    out_right_d  = out_right_q;
    rule_rd_en   = 1'b0;
    rule_rd_addr = '0;
    rule_wr_en   = 1'b0;
    tape_rd_en   = 1'b0;
    tape_wr_en   = 1'b0;
    tape_addr    = head_q;
    tape_wdata   = cell_symbol_i;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_e'(func_i) == FUNC_STEP) begin
            tape_rd_en = 1'b1;
            state_d    = ST_READ;
          end else begin
            case (func_e'(func_i))
              FUNC_LOAD_RULE: begin
                rule_wr_en = {1'b0, rule_index_i} < (RuleIdxW + 1)'(MAX_RULES);
              end
              FUNC_LOAD_CELL: begin
                tape_addr  = cell_address_i;
                tape_wr_en = {1'b0, cell_address_i} < (HeadW + 1)'(TAPE_DEPTH);
              end
              FUNC_RESTART: begin
                machine_d = start_state_q;
                head_d    = start_head_sat;
              end
              default: begin
              end
            endcase
            // Acknowledge loads and restarts at once.
            out_valid_d  = 1'b1;
            out_status_d = STATUS_ACK;
            out_state_d  = machine_d;
            out_head_d   = head_d;
            out_seen_d   = '0;
            out_put_d    = '0;
            out_right_d  = 1'b0;
          end
        end
      end

      ST_READ: begin
        if (limit == '0) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = STATUS_NO_MATCH;
            out_state_d  = machine_q;
            out_head_d   = head_q;
            out_seen_d   = tape_rdata;
            out_put_d    = '0;
            out_right_d  = 1'b0;
            state_d      = ST_IDLE;
          end
        end else begin
          rule_rd_en   = 1'b1;
          rule_rd_addr = '0;
          idx_d        = '0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (match) begin
          if (out_free) begin
            // Apply the first matching rule.
            tape_wr_en   = 1'b1;
            tape_wdata   = rule_rd_q.write_symbol;
            machine_d    = rule_rd_q.next_state;
            out_status_d = STATUS_DONE;
            if (rule_rd_q.go_right) begin
              if (head_q == HeadW'(TAPE_DEPTH - 1)) begin
                out_status_d = STATUS_OVERFLOW;
              end else begin
                head_d = head_q + HeadW'(1);
              end
            end else if (head_q != '0) begin
              head_d = head_q - HeadW'(1);
            end
            out_valid_d = 1'b1;
            out_state_d = machine_d;
            out_head_d  = head_d;
            out_seen_d  = tape_rdata;
            out_put_d   = rule_rd_q.write_symbol;
            out_right_d = rule_rd_q.go_right;
            state_d     = ST_IDLE;
          end
        end else if (last) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = STATUS_NO_MATCH;
            out_state_d  = machine_q;
            out_head_d   = head_q;
            out_seen_d   = tape_rdata;
            out_put_d    = '0;
            out_right_d  = 1'b0;
            state_d      = ST_IDLE;
          end
        end else begin
          rule_rd_en   = 1'b1;
          rule_rd_addr = idx_q + RuleIdxW'(1);
          idx_d        = idx_q + RuleIdxW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and machine registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      machine_q   <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      machine_q   <= machine_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q <= '0;
      start_head_q  <= '0;
      rule_count_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_STATE: start_state_q <= cfg_data_i[STATE_BITS-1:0];
        CFG_START_HEAD:  start_head_q  <= cfg_data_i[HeadW-1:0];
        CFG_RULE_COUNT:  rule_count_q  <= cfg_data_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_state_q  <= out_state_d;
    out_head_q   <= out_head_d;
    out_seen_q   <= out_seen_d;
    out_put_q    <= out_put_d;
    out_right_q  <= out_right_d;
  end

  // Rule table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (rule_wr_en) begin
      rule_mem[rule_index_i] <= rule_wr;
    end
    if (rule_rd_en) begin
      rule_rd_q <= rule_mem[rule_rd_addr];
    end
  end

  tms_tape #(
    .TAPE_DEPTH  (TAPE_DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_tape (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (tape_rd_en),
    .wr_en_i (tape_wr_en),
    .addr_i  (tape_addr),
    .wdata_i (tape_wdata),
    .rdata_o (tape_rdata),
    .busy_o  (tape_busy)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign current_state_o = out_state_q;
  assign head_cell_o     = out_head_q;
  assign symbol_seen_o   = out_seen_q;
  assign symbol_put_o    = out_put_q;
  assign went_right_o    = out_right_q;

endmodule
